FILE: src/linear_congruence_solver_unit_assert.svh
// Assertion macros used by the checker file lcs_checker.
`ifndef LINEAR_CONGRUENCE_SOLVER_UNIT_ASSERT_SVH
`define LINEAR_CONGRUENCE_SOLVER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LCS_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lcs check failed");
// Next-cycle implication checked outside reset.
`define LCS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lcs check failed");
`endif

FILE: src/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared state and division job types for the linear congruence solver.
// ----------------------------------------------------------------------------
`default_nettype none
package lcs_pkg;
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_GCD_DIV,
      ST_GCD_STEP,
      ST_CHECK,
      ST_INV_DIV,
      ST_INV_MUL,
      ST_INV_STEP,
      ST_FINAL_MUL,
      ST_DONE
   } lcs_state_type;

   // Division job selectors for the shared divider.
   typedef enum logic [1:0] {
      DJ_REDUCE_KA,
      DJ_REDUCE_KB,
      DJ_REDUCE_SA,
      DJ_REDUCE_SB
   } lcs_red_type;
endpackage
`default_nettype wire

FILE: src/linear_congruence_solver_unit.sv
// ----------------------------------------------------------------------------
// linear_congruence_solver_unit
// Solves (step_b - step_a) * t == (start_a - start_b) mod modulus with the
// extended Euclidean algorithm on one shared bit-serial divide/modmul unit.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | start_a start_b step_a step_b modulus
//   rsp     | out       | rsp_valid/rsp_ready   | possible steps
//
// Work: every division (four residue reductions, each Euclid quotient, the
//   divisions by the gcd) and every modular multiply runs one at a time on the
//   single shared unit, W = min(WIDTH, 32). Equal steps or a zero ring skip
//   the unit and go straight to the result.
// Reset: synchronous, clears the sequencer and the result valid.
// Stalls: req_ready is high only while idle; a held result stalls the
//   sequencer only in its last state, until that result's transfer on rsp.
`default_nettype none
module linear_congruence_solver_unit
   import lcs_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [31:0]      req_start_a,
   input  wire logic [31:0]      req_start_b,
   input  wire logic [31:0]      req_step_a,
   input  wire logic [31:0]      req_step_b,
   input  wire logic [31:0]      req_modulus,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_possible,
   output logic [31:0]           rsp_steps
);
   localparam int W  = (WIDTH < 32) ? WIDTH : 32;
   localparam int CW = $clog2(W + 1);

   lcs_state_type state_ff, state_in;

   // operands
   logic [W-1:0] sa_ff, sb_ff, ka_ff, kb_ff, m_ff;
   logic [W-1:0] sa_in, sb_in, ka_in, kb_in, m_in;
   logic [W-1:0] a_ff, b_ff, s_ff, a_in, b_in, s_in;
   logic [W-1:0] ro_ff, r_ff, co_ff, c_ff, ro_in, r_in, co_in, c_in;
   logic [1:0]   red_ff, red_in;
   logic [1:0]   phase_ff, phase_in;  // sub-step inside a state
   logic         ok_ff, ok_in;
   logic [W-1:0] t_ff, t_in;

   // shared unit: restoring divider / shift-add modular multiplier
   logic [W-1:0] u_x_ff, u_y_ff, u_d_ff, u_acc_ff;   // acc = remainder or product
   logic [W-1:0] u_x_in, u_y_in, u_d_in, u_acc_in;
   logic [CW-1:0] u_cnt_ff, u_cnt_in;
   logic          u_busy_ff, u_busy_in, u_mul_ff, u_mul_in;
   logic          u_start;
   logic          u_is_mul;
   logic [W-1:0]  u_op_x, u_op_y, u_op_d;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_possible_ff, rsp_possible_in;
   logic [W-1:0]  rsp_steps_ff, rsp_steps_in;

   // divider step: x shifts out MSB-first into remainder, quotient into x
   logic [W:0]   div_rem;
   logic [W:0]   div_sub;
   // multiplier step: y MSB-first, acc = 2*acc (+ x) mod d
   logic [W:0]   mul_dbl, mul_add;
   logic [W-1:0] mul_d1, mul_d2;
   logic         u_done;

   always_comb begin
      div_rem = {u_acc_ff, u_x_ff[W-1]};
      div_sub = div_rem - {1'b0, u_d_ff};
      mul_dbl = {u_acc_ff, 1'b0};
      mul_d1  = (mul_dbl >= {1'b0, u_d_ff}) ? W'(mul_dbl - {1'b0, u_d_ff})
                                            : mul_dbl[W-1:0];
      mul_add = {1'b0, mul_d1} + {1'b0, u_x_ff};
      mul_d2  = u_y_ff[W-1] ? ((mul_add >= {1'b0, u_d_ff})
                ? W'(mul_add - {1'b0, u_d_ff}) : mul_add[W-1:0]) : mul_d1;
      u_done  = u_busy_ff && (u_cnt_ff == CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_busy_ff <= 1'b0;
      end else begin
         u_busy_ff <= u_busy_in;
      end
      u_x_ff   <= u_x_in;
      u_y_ff   <= u_y_in;
      u_d_ff   <= u_d_in;
      u_acc_ff <= u_acc_in;
      u_cnt_ff <= u_cnt_in;
      u_mul_ff <= u_mul_in;
   end

   always_comb begin
      u_x_in = u_x_ff; u_y_in = u_y_ff; u_d_in = u_d_ff; u_acc_in = u_acc_ff;
      u_cnt_in = u_cnt_ff; u_busy_in = u_busy_ff; u_mul_in = u_mul_ff;
      if (u_start) begin
         // load operands; multiplier operands must already be below d
         u_x_in = u_op_x; u_y_in = u_op_y; u_d_in = u_op_d;
         u_acc_in = '0; u_cnt_in = CW'(W); u_busy_in = 1'b1; u_mul_in = u_is_mul;
      end else if (u_busy_ff) begin
         u_cnt_in = u_cnt_ff - CW'(1);
         if (u_done) u_busy_in = 1'b0;
         if (u_mul_ff) begin
            u_acc_in = mul_d2;
            u_y_in   = {u_y_ff[W-2:0], 1'b0};
         end else if (!div_sub[W]) begin
            u_acc_in = div_sub[W-1:0];
            u_x_in   = {u_x_ff[W-2:0], 1'b1};
         end else begin
            u_acc_in = div_rem[W-1:0];
            u_x_in   = {u_x_ff[W-2:0], 1'b0};
         end
      end
   end

   // quotient and remainder / product after the last step land here
   logic [W-1:0] u_quo, u_res;
   always_comb begin
      u_quo = u_x_in;
      u_res = u_acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sa_ff <= sa_in; sb_ff <= sb_in; ka_ff <= ka_in; kb_ff <= kb_in; m_ff <= m_in;
      a_ff <= a_in; b_ff <= b_in; s_ff <= s_in;
      ro_ff <= ro_in; r_ff <= r_in; co_ff <= co_in; c_ff <= c_in;
      red_ff <= red_in; phase_ff <= phase_in; ok_ff <= ok_in; t_ff <= t_in;
      rsp_possible_ff <= rsp_possible_in;
      rsp_steps_ff    <= rsp_steps_in;
   end

   logic [W-1:0] neg_a;   // (s - x) mod s helper
   always_comb begin
      state_in = state_ff;
      sa_in = sa_ff; sb_in = sb_ff; ka_in = ka_ff; kb_in = kb_ff; m_in = m_ff;
      a_in = a_ff; b_in = b_ff; s_in = s_ff;
      ro_in = ro_ff; r_in = r_ff; co_in = co_ff; c_in = c_ff;
      red_in = red_ff; phase_in = phase_ff; ok_in = ok_ff; t_in = t_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_possible_in = rsp_possible_ff;
      rsp_steps_in = rsp_steps_ff;
      u_start = 1'b0; u_is_mul = 1'b0;
      u_op_x = '0; u_op_y = '0; u_op_d = m_ff;
      neg_a = '0;
      req_ready = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // the result register parts the two sides: accept while it waits
            req_ready = 1'b1;
            if (req_valid) begin
               sa_in = req_start_a[W-1:0]; sb_in = req_start_b[W-1:0];
               ka_in = req_step_a[W-1:0];  kb_in = req_step_b[W-1:0];
               m_in  = req_modulus[W-1:0];
               ok_in = 1'b0; t_in = '0; red_in = DJ_REDUCE_KA; phase_in = 2'd0;
               if (req_modulus[W-1:0] == '0 || req_step_a[W-1:0] == req_step_b[W-1:0])
                  state_in = ST_DONE;
               else
                  state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // reduce the four inputs modulo m, one division each
            if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_op_d = m_ff;
               case (red_ff)
                  DJ_REDUCE_KA: u_op_x = ka_ff;
                  DJ_REDUCE_KB: u_op_x = kb_ff;
                  DJ_REDUCE_SA: u_op_x = sa_ff;
                  default:      u_op_x = sb_ff;
               endcase
               phase_in = 2'd1;
            end else if (u_done) begin
               phase_in = 2'd0;
               case (red_ff)
                  DJ_REDUCE_KA: begin ka_in = u_res; red_in = DJ_REDUCE_KB; end
                  DJ_REDUCE_KB: begin kb_in = u_res; red_in = DJ_REDUCE_SA; end
                  DJ_REDUCE_SA: begin sa_in = u_res; red_in = DJ_REDUCE_SB; end
                  default: begin
                     sb_in = u_res;
                     a_in = (kb_ff >= ka_ff) ? W'(kb_ff - ka_ff) : W'(m_ff - ka_ff + kb_ff);
                     b_in = (sa_ff >= u_res) ? W'(sa_ff - u_res) : W'(m_ff - u_res + sa_ff);
                     ro_in = (kb_ff >= ka_ff) ? W'(kb_ff - ka_ff)
                                              : W'(m_ff - ka_ff + kb_ff);
                     r_in = m_ff;
                     state_in = ST_GCD_DIV;
                  end
               endcase
            end
         end
         ST_GCD_DIV: begin
            // gcd(a, m): ro/r hold the running pair
            if (r_ff == '0) begin
               state_in = ST_CHECK; phase_in = 2'd0;
            end else if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_op_x = ro_ff; u_op_d = r_ff; phase_in = 2'd1;
            end else if (u_done) begin
               ro_in = r_ff; r_in = u_res; phase_in = 2'd0;
            end
         end
         ST_CHECK: begin
            // ro = g; phases: b mod g with b/g, then m/g
            if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_op_x = b_ff; u_op_d = ro_ff; phase_in = 2'd1;
            end else if (u_done && phase_ff == 2'd1) begin
               if (u_res != '0) begin
                  state_in = ST_DONE;
               end else begin
                  b_in = u_quo; ok_in = 1'b1; phase_in = 2'd2;
               end
            end else if (!u_busy_ff && phase_ff == 2'd2) begin
               u_start = 1'b1; u_op_x = m_ff; u_op_d = ro_ff; phase_in = 2'd3;
            end else if (u_done && phase_ff == 2'd3) begin
               s_in = u_quo;
               if (u_quo == W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GCD_STEP; phase_in = 2'd0;
               end
            end
         end
         ST_GCD_STEP: begin
            // a / g (already < s since a < m); set up the inverse pair
            if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_op_x = a_ff; u_op_d = ro_ff; phase_in = 2'd1;
            end else if (u_done) begin
               ro_in = u_quo; r_in = s_ff; co_in = W'(1); c_in = '0;
               phase_in = 2'd0; state_in = ST_INV_DIV;
            end
         end
         ST_INV_DIV: begin
            if (r_ff == '0) begin
               state_in = ST_FINAL_MUL; phase_in = 2'd0;
            end else if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_op_x = ro_ff; u_op_d = r_ff; phase_in = 2'd1;
            end else if (u_done) begin
               // quotient held in a, remainder in b? keep b: stash in t
               a_in = u_quo; t_in = u_res; phase_in = 2'd0; state_in = ST_INV_MUL;
            end
         end
         ST_INV_MUL: begin
            // q mod s: q <= s here since ro <= s at every step, so one compare
            // and subtract reduces it
            if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_is_mul = 1'b1;
               u_op_x = (a_ff >= s_ff) ? W'(a_ff - s_ff) : a_ff;
               u_op_y = c_ff; u_op_d = s_ff; phase_in = 2'd1;
            end else if (u_done) begin
               neg_a = (u_res == '0) ? '0 : W'(s_ff - u_res);
               co_in = c_ff;
               c_in  = ({1'b0, co_ff} + {1'b0, neg_a} >= {1'b0, s_ff})
                       ? W'(co_ff + neg_a - s_ff) : W'(co_ff + neg_a);
               ro_in = r_ff; r_in = t_ff; phase_in = 2'd0; state_in = ST_INV_DIV;
            end
         end
         ST_FINAL_MUL: begin
            if (!u_busy_ff && phase_ff == 2'd0) begin
               u_start = 1'b1; u_is_mul = 1'b1;
               u_op_x = co_ff; u_op_y = b_ff; u_op_d = s_ff; phase_in = 2'd1;
            end else if (u_done) begin
               t_in = u_res; phase_in = 2'd0; state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold here while the previous result still waits for its transfer
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_possible_in = ok_ff;
               rsp_steps_in = ok_ff ? t_ff : '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_possible = rsp_possible_ff;
   assign rsp_steps    = 32'(rsp_steps_ff);
endmodule
`default_nettype wire

FILE: src/lcs_checker.sv
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks for the linear congruence solver.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_congruence_solver_unit_assert.svh"
module lcs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_possible,
   input wire logic [31:0] rsp_steps
);
   // flag held while stalled
   `LCS_ASSERT_NEXT(a_flag_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_possible))
   // impossible results report zero steps
   `LCS_ASSERT_IMPL(a_zero_fail, clock, reset, rsp_valid && !rsp_possible, rsp_steps == 32'd0)
   // req_ready is low in the cycle after an accepted request
   `LCS_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready)
   // result held while stalled
   `LCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_steps))
endmodule

bind linear_congruence_solver_unit lcs_checker u_lcs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_possible(rsp_possible),
   .rsp_steps(rsp_steps)
);
`default_nettype wire
